// ===== src/mhpq_pkg.sv =====
// Package for the min-heap priority queue: beat types, action and status codes,
// and controller command/status structs. No dependencies.
package mhpq_pkg;

  localparam int KEY_W   = 16;
  localparam int TILE_W  = 16;
  localparam int COUNT_W = 8;

  typedef enum logic [1:0] {
    ACT_INSERT  = 2'd0,
    ACT_EXTRACT = 2'd1,
    ACT_DECREASE = 2'd2,
    ACT_FIND    = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_FULL     = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_NOTDEC   = 3'd4
  } status_t;

  typedef struct packed {
    logic [1:0]        action;
    logic [KEY_W-1:0]  item_key;
    logic [TILE_W-1:0] item_tile;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [KEY_W-1:0]   out_key;
    logic [TILE_W-1:0]  out_tile;
    logic [COUNT_W-1:0] entry_count;
  } out_beat_t;

  // Datapath operations, one per controller state step.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,       // capture the input beat
    OP_APPEND,     // write new entry at fill_count, pos = fill_count
    OP_UP_RD,      // read the parent of pos
    OP_UP_CMP,     // compare with parent, swap if smaller
    OP_LAST_RD,    // read root and last slot
    OP_LAST_MV,    // move last to root, capture root as result
    OP_DN_RD,      // read both children of pos
    OP_DN_CMP,     // pick best child and swap
    OP_SCAN_RD,    // read slot pos for tile search
    OP_SCAN_NEXT,  // no match, advance pos
    OP_FOUND,      // capture the matching entry as result
    OP_DEC_WR,     // write new key at pos
    OP_RESULT      // load the output register
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [2:0] status;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       full;
    logic       empty;
    logic       at_root;    // pos is the root
    logic       up_swap;    // entry is smaller than its parent
    logic       dn_done;    // no children
    logic       dn_swap;    // a child takes the place of the entry
    logic       scan_end;   // pos reached fill_count
    logic       scan_hit;
    logic       not_less;   // new key not smaller than stored key
    logic       out_busy;
  } dp_stat_t;

endpackage

// ===== src/mhpq_datapath.sv =====
// Datapath of the min-heap: key/tile memories, position and fill counters,
// comparators and output register. Uses mhpq_pkg.
module mhpq_datapath #(
  parameter int CAPACITY  = 128
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mhpq_pkg::in_beat_t  in_beat,
  input  mhpq_pkg::dp_cmd_t   cmd,
  output mhpq_pkg::dp_stat_t  stat,
  output mhpq_pkg::out_beat_t out_beat,
  output logic                out_valid,
  input  logic                out_stall
);
  import mhpq_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = AW + 2;

  logic [KEY_W-1:0]  keys_mem  [CAPACITY];
  logic [TILE_W-1:0] tiles_mem [CAPACITY];

  logic [1:0]        act_r;
  logic [KEY_W-1:0]  key_r;
  logic [TILE_W-1:0] tile_r;
  logic [CW-1:0]     fill_r;
  logic [PW-1:0]     pos_r;
  logic [KEY_W-1:0]  cur_k_r;   // entry being sifted
  logic [TILE_W-1:0] cur_t_r;
  logic [KEY_W-1:0]  rkey_r;
  logic [TILE_W-1:0] rtile_r;
  logic              ovalid_r;
  out_beat_t         obeat_r;
  logic [KEY_W-1:0]  rd_ka_r, rd_kb_r;
  logic [TILE_W-1:0] rd_ta_r, rd_tb_r;

  logic [PW-1:0]     parent, lc, rc, fill_p, last, child_p;
  logic [AW-1:0]     ra_addr, rb_addr;
  logic              we_a, we_b;
  logic [AW-1:0]     wa_addr, wb_addr;
  logic [KEY_W-1:0]  wa_key, wb_key;
  logic [TILE_W-1:0] wa_tile, wb_tile;
  logic              has_right, take_l, take_r, dn_swap, up_swap;
  logic [KEY_W-1:0]  left_best_k, child_k;
  logic [TILE_W-1:0] child_t;

  assign fill_p = PW'(fill_r);
  assign last   = fill_p - PW'(1);
  assign parent = (pos_r - PW'(1)) >> 1;
  assign lc     = {pos_r[PW-2:0], 1'b1};
  assign rc     = lc + PW'(1);

  // Sift-down choice: left if <= current, right if <= picked; an equal child wins.
  assign has_right   = rc < fill_p;
  assign take_l      = rd_ka_r <= cur_k_r;
  assign left_best_k = take_l ? rd_ka_r : cur_k_r;
  assign take_r      = has_right && (rd_kb_r <= left_best_k);
  assign dn_swap     = take_l || take_r;
  assign child_k     = take_r ? rd_kb_r : rd_ka_r;
  assign child_t     = take_r ? rd_tb_r : rd_ta_r;
  assign child_p     = take_r ? rc : lc;

  assign up_swap = (pos_r != '0) && (cur_k_r < rd_kb_r);

  // Read addresses for the two ports.
  always_comb begin
    ra_addr = pos_r[AW-1:0];
    rb_addr = parent[AW-1:0];
    unique case (cmd.op)
      OP_LAST_RD: begin
        ra_addr = '0;
        rb_addr = last[AW-1:0];
      end
      OP_DN_RD: begin
        ra_addr = lc[AW-1:0];
        rb_addr = rc[AW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    rd_ka_r <= keys_mem[ra_addr];
    rd_ta_r <= tiles_mem[ra_addr];
    rd_kb_r <= keys_mem[rb_addr];
    rd_tb_r <= tiles_mem[rb_addr];
  end

  always_comb begin
    we_a = 1'b0; we_b = 1'b0;
    wa_addr = pos_r[AW-1:0]; wb_addr = parent[AW-1:0];
    wa_key = cur_k_r; wa_tile = cur_t_r; wb_key = cur_k_r; wb_tile = cur_t_r;
    unique case (cmd.op)
      OP_APPEND: begin
        we_a = 1'b1; wa_addr = fill_r[AW-1:0]; wa_key = key_r; wa_tile = tile_r;
      end
      OP_UP_CMP: begin
        // The parent moves down to pos and the entry moves up to the parent.
        if (up_swap) begin
          we_a = 1'b1; wa_key = rd_kb_r; wa_tile = rd_tb_r;
          we_b = 1'b1;
        end
      end
      OP_LAST_MV: begin
        we_a = 1'b1; wa_addr = '0; wa_key = rd_kb_r; wa_tile = rd_tb_r;
      end
      OP_DN_CMP: begin
        if (dn_swap) begin
          we_a = 1'b1; wa_key = child_k; wa_tile = child_t;
          we_b = 1'b1; wb_addr = child_p[AW-1:0];
        end
      end
      OP_DEC_WR: begin
        we_a = 1'b1; wa_key = key_r; wa_tile = tile_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we_a) begin
      keys_mem[wa_addr]  <= wa_key;
      tiles_mem[wa_addr] <= wa_tile;
    end
    if (we_b) begin
      keys_mem[wb_addr]  <= wb_key;
      tiles_mem[wb_addr] <= wb_tile;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      ovalid_r <= (cmd.op == OP_RESULT) || (ovalid_r && out_stall);
      unique case (cmd.op)
        OP_LOAD: begin
          act_r  <= in_beat.action;
          key_r  <= in_beat.item_key;
          tile_r <= in_beat.item_tile;
          pos_r  <= '0;
        end
        OP_APPEND: begin
          pos_r   <= fill_p;
          fill_r  <= fill_r + CW'(1);
          cur_k_r <= key_r; cur_t_r <= tile_r;
          rkey_r  <= key_r; rtile_r <= tile_r;
        end
        OP_UP_CMP: begin
          if (up_swap) pos_r <= parent;
        end
        OP_LAST_RD: fill_r <= fill_r - CW'(1);
        OP_LAST_MV: begin
          rkey_r  <= rd_ka_r; rtile_r <= rd_ta_r;
          cur_k_r <= rd_kb_r; cur_t_r <= rd_tb_r;
          pos_r   <= '0;
        end
        OP_DN_CMP: begin
          if (dn_swap) pos_r <= child_p;
        end
        OP_SCAN_NEXT: pos_r <= pos_r + PW'(1);
        OP_FOUND: begin
          rkey_r <= rd_ka_r; rtile_r <= rd_ta_r;
        end
        OP_DEC_WR: begin
          cur_k_r <= key_r; cur_t_r <= tile_r;
          rkey_r  <= key_r; rtile_r <= tile_r;
        end
        OP_RESULT: begin
          obeat_r.status      <= cmd.status;
          obeat_r.out_key     <= (cmd.status == ST_OK) ? rkey_r : '0;
          obeat_r.out_tile    <= (cmd.status == ST_OK) ? rtile_r : '0;
          obeat_r.entry_count <= COUNT_W'(fill_r);
        end
        default: ;
      endcase
    end
  end

  assign stat.action   = act_r;
  assign stat.full     = fill_p >= PW'(CAPACITY);
  assign stat.empty    = fill_r == '0;
  assign stat.at_root  = pos_r == '0;
  assign stat.up_swap  = up_swap;
  assign stat.dn_done  = lc >= fill_p;
  assign stat.dn_swap  = dn_swap;
  assign stat.scan_end = pos_r >= fill_p;
  assign stat.scan_hit = rd_ta_r == tile_r;
  assign stat.not_less = !(key_r < rd_ka_r);
  assign stat.out_busy = ovalid_r && out_stall;

  assign out_valid = ovalid_r;
  assign out_beat  = obeat_r;
endmodule

// ===== src/mhpq_ctrl.sv =====
// Controller state machine of the min-heap: sequences datapath steps per action.
// Uses mhpq_pkg.
module mhpq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  mhpq_pkg::dp_stat_t stat,
  output mhpq_pkg::dp_cmd_t  cmd
);
  import mhpq_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_DISP  = 10'b0000000010,
    S_UPRD  = 10'b0000000100,
    S_UPCMP = 10'b0000001000,
    S_LMV   = 10'b0000010000,
    S_DNRD  = 10'b0000100000,
    S_DNCMP = 10'b0001000000,
    S_SRD   = 10'b0010000000,
    S_SCMP  = 10'b0100000000,
    S_RES   = 10'b1000000000
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] st_r, st_nxt;

  assign in_stall = state_r != S_IDLE;

  always_comb begin
    state_nxt = state_r;
    st_nxt = st_r;
    cmd.op = OP_NONE;
    cmd.status = st_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = OP_LOAD; state_nxt = S_DISP; st_nxt = ST_OK;
        end
      end
      S_DISP: begin
        unique case (stat.action)
          ACT_INSERT: begin
            if (stat.full) begin
              st_nxt = ST_FULL; state_nxt = S_RES;
            end else begin
              cmd.op = OP_APPEND; state_nxt = S_UPRD;
            end
          end
          ACT_EXTRACT: begin
            if (stat.empty) begin
              st_nxt = ST_EMPTY; state_nxt = S_RES;
            end else begin
              cmd.op = OP_LAST_RD; state_nxt = S_LMV;
            end
          end
          ACT_DECREASE, ACT_FIND: state_nxt = S_SRD;
        endcase
      end
      S_UPRD: begin
        if (stat.at_root) state_nxt = S_RES;
        else begin
          cmd.op = OP_UP_RD; state_nxt = S_UPCMP;
        end
      end
      S_UPCMP: begin
        cmd.op = OP_UP_CMP;
        state_nxt = stat.up_swap ? S_UPRD : S_RES;
      end
      S_LMV: begin
        cmd.op = OP_LAST_MV; state_nxt = S_DNRD;
      end
      S_DNRD: begin
        if (stat.dn_done) state_nxt = S_RES;
        else begin
          cmd.op = OP_DN_RD; state_nxt = S_DNCMP;
        end
      end
      S_DNCMP: begin
        cmd.op = OP_DN_CMP;
        state_nxt = stat.dn_swap ? S_DNRD : S_RES;
      end
      S_SRD: begin
        if (stat.scan_end) begin
          st_nxt = ST_NOTFOUND; state_nxt = S_RES;
        end else begin
          cmd.op = OP_SCAN_RD; state_nxt = S_SCMP;
        end
      end
      S_SCMP: begin
        priority if (!stat.scan_hit) begin
          cmd.op = OP_SCAN_NEXT; state_nxt = S_SRD;
        end else if (stat.action == ACT_FIND) begin
          cmd.op = OP_FOUND; state_nxt = S_RES;
        end else if (stat.not_less) begin
          st_nxt = ST_NOTDEC; state_nxt = S_RES;
        end else begin
          cmd.op = OP_DEC_WR; state_nxt = S_UPRD;
        end
      end
      S_RES: begin
        if (!stat.out_busy) begin
          cmd.op = OP_RESULT; state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      st_r <= ST_OK;
    end else begin
      state_r <= state_nxt;
      st_r <= st_nxt;
    end
  end
endmodule

// ===== src/min_heap_priority_queue.sv =====
// Top level of the min-heap priority queue with decrease-key.
// Instantiates mhpq_ctrl and mhpq_datapath; uses mhpq_pkg.

// A binary min-heap of up to CAPACITY key/tile entries, one result beat per
// input beat. The block handles one beat at a time and stalls its input until
// the result is registered. Insert and decrease-key take a read step and a
// compare step per sift-up level and extract the same two steps per sift-down
// level; a heap of the default capacity is eight levels deep. Find and
// decrease-key first scan the tile memory one slot at a time, a read step and
// a compare step per slot, which sets the worst case: a decrease-key that hits
// the last slot and then sifts to the root. A waiting result is further held
// by out_stall. Storage is two dual-port memories, one for keys and one for
// tiles, with registered reads. Values read from slots outside the heap are
// never used.
module min_heap_priority_queue #(
  parameter int CAPACITY  = 128
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mhpq_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output mhpq_pkg::out_beat_t out_data
);
  import mhpq_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  mhpq_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .stat, .cmd
  );

  mhpq_datapath #(
    .CAPACITY(CAPACITY)
  ) u_dp (
    .clk, .rst_n, .in_beat(in_data), .cmd, .stat,
    .out_beat(out_data), .out_valid, .out_stall
  );
endmodule

// ===== tb/sv/mhpq_checker.sv =====
// Checker for the min-heap priority queue: watches both channels, keeps its own
// heap image, predicts one result per accepted input beat and compares it.
// Depends on mhpq_pkg.
module mhpq_checker #(
  parameter int CAPACITY = 128
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  mhpq_pkg::in_beat_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  mhpq_pkg::out_beat_t out_data,
  output int                  fail_count,
  output int                  pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import mhpq_pkg::*;

  logic [KEY_W-1:0]  keys  [CAPACITY];
  logic [TILE_W-1:0] tiles [CAPACITY];
  int                fill;
  out_beat_t         want_q [$];

  assign pending = want_q.size();

  function automatic void swap_slots(int a, int b);
    logic [KEY_W-1:0]  k;
    logic [TILE_W-1:0] t;
    k = keys[a];  keys[a] = keys[b];  keys[b] = k;
    t = tiles[a]; tiles[a] = tiles[b]; tiles[b] = t;
  endfunction

  function automatic void bubble_up(int pos);
    int up;
    while (pos > 0) begin
      up = (pos - 1) / 2;
      if (!(keys[pos] < keys[up])) break;
      swap_slots(pos, up);
      pos = up;
    end
  endfunction

  function automatic void bubble_down(int pos);
    int lc, rc, best;
    while (pos < fill) begin
      lc = 2 * pos + 1;
      rc = 2 * pos + 2;
      best = pos;
      if (lc < fill && keys[lc] <= keys[pos]) best = lc;
      if (rc < fill && keys[rc] <= keys[best]) best = rc;
      if (best == pos) break;
      swap_slots(pos, best);
      pos = best;
    end
  endfunction

  function automatic int locate_tile(logic [TILE_W-1:0] t);
    for (int i = 0; i < fill; i++)
      if (tiles[i] == t) return i;
    return -1;
  endfunction

  function automatic out_beat_t apply_beat(in_beat_t b);
    out_beat_t r;
    int        pos;
    r = '0;
    r.status = ST_OK;
    case (action_t'(b.action))
      ACT_INSERT: begin
        if (fill >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          keys[fill] = b.item_key;
          tiles[fill] = b.item_tile;
          fill++;
          bubble_up(fill - 1);
          r.out_key = b.item_key;
          r.out_tile = b.item_tile;
        end
      end
      ACT_EXTRACT: begin
        if (fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.out_key = keys[0];
          r.out_tile = tiles[0];
          fill--;
          keys[0] = keys[fill];
          tiles[0] = tiles[fill];
          if (fill > 0) bubble_down(0);
        end
      end
      ACT_DECREASE: begin
        pos = locate_tile(b.item_tile);
        if (pos < 0) begin
          r.status = ST_NOTFOUND;
        end else if (!(b.item_key < keys[pos])) begin
          r.status = ST_NOTDEC;
        end else begin
          keys[pos] = b.item_key;
          bubble_up(pos);
          r.out_key = b.item_key;
          r.out_tile = b.item_tile;
        end
      end
      default: begin
        pos = locate_tile(b.item_tile);
        if (pos < 0) begin
          r.status = ST_NOTFOUND;
        end else begin
          r.out_key = keys[pos];
          r.out_tile = tiles[pos];
        end
      end
    endcase
    r.entry_count = fill[COUNT_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    out_beat_t w;
    if (!rst_n) begin
      fill = 0;
      fail_count <= 0;
      want_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (want_q.size() == 0) begin
          $error("result beat with no input beat pending: %p", out_data);
          fail_count <= fail_count + 1;
        end else begin
          w = want_q.pop_front();
          if (out_data != w) begin
            fail_count <= fail_count + 1;
            if (out_data.status != w.status)
              $error("status expected %0d actual %0d", w.status, out_data.status);
            if (out_data.out_key != w.out_key)
              $error("out_key expected %0d actual %0d", w.out_key, out_data.out_key);
            if (out_data.out_tile != w.out_tile)
              $error("out_tile expected %0d actual %0d", w.out_tile, out_data.out_tile);
            if (out_data.entry_count != w.entry_count)
              $error("entry_count expected %0d actual %0d", w.entry_count,
                     out_data.entry_count);
          end
        end
      end
      if (in_valid && !in_stall)
        want_q.push_back(apply_beat(in_data));
    end
  end
endmodule

// ===== tb/sv/tb_min_heap_priority_queue.sv =====
// Top of the min-heap priority queue testbench: clock, reset, stimulus and the
// verdict. Depends on mhpq_pkg, mhpq_checker and min_heap_priority_queue.
module tb_min_heap_priority_queue;
  timeunit 1ns;
  timeprecision 1ps;
  import mhpq_pkg::*;

  localparam int CAP = 128;
  // Worst correct beat is a full scan plus sifts, and the receiver adds its
  // own stall runs. Leave a wide margin.
  localparam int CYCLE_LIMIT = 3000000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_beat_t out_data;
  int        fail_count;
  int        pending;
  int        cycles = 0;

  // Tiles handed out so far, so that decrease and find mostly hit real entries.
  logic [TILE_W-1:0] used_tiles [$];
  int                live;

  min_heap_priority_queue #(.CAPACITY(CAP)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  mhpq_checker #(.CAPACITY(CAP)) chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run-time guard: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // The receiver stalls in runs of its own, with quiet stretches where it
  // never stalls at all.
  initial begin
    int run;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (run > 0) begin
        run--;
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2: begin out_stall <= 1'b1; run = $urandom_range(0, 6); end
          3:       begin out_stall <= 1'b1; run = $urandom_range(10, 40); end
          4:       begin out_stall <= 1'b0; run = $urandom_range(100, 400); end
          default: begin out_stall <= 1'b0; run = $urandom_range(0, 8); end
        endcase
      end
    end
  end

  // Sends one beat: valid rises at a falling edge and holds until the beat is
  // taken at a rising edge. Valid is lowered afterwards only by the gap logic or at the end of the stimulus.
  task automatic send_beat(action_t act, logic [KEY_W-1:0] k, logic [TILE_W-1:0] t);
    in_data.action <= act;
    in_data.item_key <= k;
    in_data.item_tile <= t;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    // Track the entry count roughly, so the mix keeps the heap in range.
    if (act == ACT_INSERT && live < CAP) begin
      live++;
      used_tiles.push_back(t);
    end else if (act == ACT_EXTRACT && live > 0) begin
      live--;
    end
  endtask

  // Idle between bursts: valid drops for a random gap.
  task automatic maybe_gap(ref int burst);
    if (burst > 0) begin
      burst--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst = $urandom_range(0, 20);
    end
  endtask

  function automatic logic [TILE_W-1:0] pick_tile();
    if (used_tiles.size() > 0 && $urandom_range(0, 4) != 0)
      return used_tiles[$urandom_range(0, used_tiles.size() - 1)];
    return TILE_W'($urandom());
  endfunction

  initial begin
    int                burst;
    int                drain;
    int                sel;
    logic [KEY_W-1:0]  k;
    action_t           act;
    live = 0;
    burst = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty extract, misses on an empty heap, field extremes,
    // duplicate tiles, equal keys, refused and accepted decreases.
    send_beat(ACT_EXTRACT, 16'h0000, 16'h0000);
    send_beat(ACT_FIND, 16'h0000, 16'hFFFF);
    send_beat(ACT_DECREASE, 16'h0000, 16'h0000);
    send_beat(ACT_INSERT, 16'hFFFF, 16'hFFFF);
    send_beat(ACT_INSERT, 16'h0000, 16'h0000);
    send_beat(ACT_INSERT, 16'h8000, 16'h1234);
    send_beat(ACT_INSERT, 16'h8000, 16'h1234);
    send_beat(ACT_INSERT, 16'h8000, 16'h5555);
    send_beat(ACT_FIND, 16'h0000, 16'h1234);
    send_beat(ACT_DECREASE, 16'h8000, 16'h1234);
    send_beat(ACT_DECREASE, 16'hFFFF, 16'h5555);
    send_beat(ACT_DECREASE, 16'h0001, 16'hFFFF);
    send_beat(ACT_DECREASE, 16'h0000, 16'h7777);
    send_beat(ACT_FIND, 16'h0000, 16'hAAAA);
    repeat (7) send_beat(ACT_EXTRACT, 16'h0000, 16'h0000);

    // Fill to capacity, then one refused insert, a find and a decrease, then drain it all.
    for (int i = 0; i < CAP; i++)
      send_beat(ACT_INSERT, KEY_W'($urandom_range(0, 15)), TILE_W'(i));
    send_beat(ACT_INSERT, 16'hFFFF, 16'hFFFF);
    send_beat(ACT_FIND, 16'h0000, TILE_W'(CAP - 1));
    send_beat(ACT_DECREASE, 16'h0000, TILE_W'(CAP - 1));
    for (int i = 0; i < CAP + 1; i++)
      send_beat(ACT_EXTRACT, 16'h0000, 16'h0000);
    used_tiles.delete();

    // Random part: phases that lean toward growth or toward draining.
    for (int n = 0; n < 1400; n++) begin
      maybe_gap(burst);
      sel = $urandom_range(0, 99);
      if (((n / 200) % 2) == 0) begin
        if (sel < 55) act = ACT_INSERT;
        else if (sel < 70) act = ACT_EXTRACT;
        else if (sel < 88) act = ACT_DECREASE;
        else act = ACT_FIND;
      end else begin
        if (sel < 25) act = ACT_INSERT;
        else if (sel < 70) act = ACT_EXTRACT;
        else if (sel < 88) act = ACT_DECREASE;
        else act = ACT_FIND;
      end
      // Narrow keys now and then, so equal keys meet in the sifts.
      k = ($urandom_range(0, 2) == 0) ? KEY_W'($urandom_range(0, 7)) : KEY_W'($urandom());
      if (act == ACT_INSERT)
        send_beat(act, k, ($urandom_range(0, 3) == 0) ? pick_tile() : TILE_W'($urandom()));
      else
        send_beat(act, k, pick_tile());
      if (used_tiles.size() > 300) used_tiles.delete();
    end
    in_valid <= 1'b0;

    // Wait for every outstanding result, then a short tail for stray beats.
    while (pending != 0) @(posedge clk);
    drain = 0;
    while (drain < 300) begin
      @(posedge clk);
      drain++;
    end
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
